[src/cfbl_pkg.sv]
// Package for the chained free-block list.
// Holds the request/response payload types, opcodes, result kinds and the
// sequencer state type. No dependencies.
package cfbl_pkg;

   // default stack capacity
   localparam int LIST_SIZE_DEF = 32;

   // opcodes
   localparam logic [1:0] OP_FREE  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // result kinds
   typedef enum logic [2:0] {
      KIND_FREED     = 3'd0,
      KIND_ALLOCATED = 3'd1,
      KIND_SPILL     = 3'd2,
      KIND_NO_SPACE  = 3'd3,
      KIND_BUSY      = 3'd4,
      KIND_FILL_ACK  = 3'd5
   } cfbl_kind_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] freed_block;
      logic [15:0] fill_word;
   } cfbl_req_type;

   typedef struct packed {
      cfbl_kind_type kind;
      logic [15:0]   block_number;
      logic [15:0]   spill_word;
      logic          refill_needed;
      logic          last;
   } cfbl_rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ALLOC_CHK,
      ST_SPILL_OUT
   } cfbl_state_type;

endpackage

[src/cfbl_store.sv]
// Entry store of the free-block stack: one write port, one registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on cfbl_pkg for the default capacity.
module cfbl_store #(
   parameter int LIST_SIZE = cfbl_pkg::LIST_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(LIST_SIZE)-1:0] wr_addr,
   input  logic [15:0]                  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(LIST_SIZE)-1:0] rd_addr,
   output logic [15:0]                  rd_data
);
   logic [15:0]          mem [LIST_SIZE];
   logic [LIST_SIZE-1:0] vld_ff;
   logic [15:0]          rd_data_ff;
   logic                 rd_vld_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : 16'd0;

endmodule

[src/cfbl_ctrl.sv]
// Sequencer and datapath of the free-block list: decodes a request, reads
// the store for allocate, walks it for spill, and hands result items downstream.
// Depends on cfbl_pkg.
module cfbl_ctrl #(
   parameter int LIST_SIZE = cfbl_pkg::LIST_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  cfbl_pkg::cfbl_req_type       req_data,
   output logic                         res_valid,
   input  logic                         res_ready,
   output cfbl_pkg::cfbl_rsp_type       res_data,
   output logic                         wr_en,
   output logic [$clog2(LIST_SIZE)-1:0] wr_addr,
   output logic [15:0]                  wr_data,
   output logic                         rd_en,
   output logic [$clog2(LIST_SIZE)-1:0] rd_addr,
   input  logic [15:0]                  rd_data
);
   localparam int AW = $clog2(LIST_SIZE);
   localparam int CW = $clog2(LIST_SIZE + 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(LIST_SIZE);
   localparam logic [AW-1:0] LAST_IDX  = AW'(LIST_SIZE - 1);
   localparam logic [15:0]   FULL_WORD = 16'(LIST_SIZE);

   cfbl_pkg::cfbl_state_type state_ff, state_in;
   cfbl_pkg::cfbl_req_type   req_ff, req_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     pend_ff, pend_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            idx_ff, idx_in;

   logic          spill_go;
   logic          alloc_go;
   logic          last_word;
   logic [CW-1:0] top_cnt;

   // request decode
   assign spill_go  = (req_ff.opcode == cfbl_pkg::OP_FREE) && !pend_ff && (count_ff >= FULL_CNT);
   assign alloc_go  = (req_ff.opcode == cfbl_pkg::OP_ALLOC) && !pend_ff && (count_ff != '0);
   assign last_word = (idx_ff == LAST_IDX);
   assign top_cnt   = count_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfbl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cfbl_pkg::ST_EXEC;
            end
         end
         cfbl_pkg::ST_EXEC: begin
            if (spill_go) begin
               if (res_ready) begin
                  state_in = cfbl_pkg::ST_SPILL_OUT;
               end
            end else if (alloc_go) begin
               state_in = cfbl_pkg::ST_ALLOC_CHK;
            end else if (res_ready) begin
               state_in = cfbl_pkg::ST_IDLE;
            end
         end
         cfbl_pkg::ST_ALLOC_CHK: begin
            if (res_ready) begin
               state_in = cfbl_pkg::ST_IDLE;
            end
         end
         cfbl_pkg::ST_SPILL_OUT: begin
            if (res_ready && last_word) begin
               state_in = cfbl_pkg::ST_IDLE;
            end
         end
         default: state_in = cfbl_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready = 1'b0;
      req_in    = req_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      res_valid = 1'b0;
      res_data  = '{kind: cfbl_pkg::KIND_BUSY, block_number: 16'd0, spill_word: 16'd0,
                    refill_needed: 1'b0, last: 1'b1};
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = 16'd0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      case (state_ff)
         cfbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
            end
         end
         cfbl_pkg::ST_EXEC: begin
            if (req_ff.opcode == cfbl_pkg::OP_FILL) begin
               // fill word: count first, then entries bottom up
               res_valid = 1'b1;
               if (pend_ff) begin
                  res_data.kind = cfbl_pkg::KIND_FILL_ACK;
                  if (res_ready) begin
                     if (pos_ff == '0) begin
                        count_in = (req_ff.fill_word > FULL_WORD) ? FULL_CNT
                                                                  : req_ff.fill_word[CW-1:0];
                        pos_in   = CW'(1);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(pos_ff - 1'b1);
                        wr_data = req_ff.fill_word;
                        if (pos_ff >= FULL_CNT) begin
                           pend_in = 1'b0;
                           pos_in  = '0;
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end
                  end
               end
            end else if (spill_go) begin
               // spill header: the count, then start the entry walk
               res_valid              = 1'b1;
               res_data.kind          = cfbl_pkg::KIND_SPILL;
               res_data.block_number  = req_ff.freed_block;
               res_data.spill_word    = 16'(count_ff);
               res_data.last          = 1'b0;
               if (res_ready) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
                  idx_in  = '0;
               end
            end else if (alloc_go) begin
               rd_en   = 1'b1;
               rd_addr = top_cnt[AW-1:0];
            end else if ((req_ff.opcode == cfbl_pkg::OP_FREE) && !pend_ff) begin
               // plain push
               res_valid             = 1'b1;
               res_data.kind         = cfbl_pkg::KIND_FREED;
               res_data.block_number = req_ff.freed_block;
               if (res_ready) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_ff.freed_block;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               res_valid = 1'b1;
               if ((req_ff.opcode == cfbl_pkg::OP_ALLOC) && !pend_ff) begin
                  res_data.kind = cfbl_pkg::KIND_NO_SPACE;
               end
            end
         end
         cfbl_pkg::ST_ALLOC_CHK: begin
            res_valid = 1'b1;
            if (rd_data == 16'd0) begin
               // end-of-chain marker
               res_data.kind = cfbl_pkg::KIND_NO_SPACE;
            end else begin
               res_data.kind          = cfbl_pkg::KIND_ALLOCATED;
               res_data.block_number  = rd_data;
               res_data.refill_needed = (top_cnt == '0);
               if (res_ready) begin
                  wr_en    = 1'b1;
                  wr_addr  = top_cnt[AW-1:0];
                  wr_data  = 16'd0;
                  count_in = top_cnt;
                  if (top_cnt == '0) begin
                     pend_in = 1'b1;
                     pos_in  = '0;
                  end
               end
            end
         end
         cfbl_pkg::ST_SPILL_OUT: begin
            res_valid             = 1'b1;
            res_data.kind         = cfbl_pkg::KIND_SPILL;
            res_data.block_number = req_ff.freed_block;
            res_data.spill_word   = rd_data;
            res_data.last         = last_word;
            if (res_ready) begin
               if (last_word) begin
                  // stack emptied, then the push
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_ff.freed_block;
                  count_in = CW'(1);
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfbl_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         pos_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
      end
   end

   // captured request
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

endmodule

[src/chained_free_block_list.sv]
// Top level of the chained free-block list: sequencer, entry store and
// response output register. Depends on cfbl_pkg, cfbl_store, cfbl_ctrl.
//
// Usage:
//   req_*  : request channel (valid/ready). opcode 0 frees freed_block,
//            1 allocates a block, 2 delivers one word of a chained block.
//   rsp_*  : result channel (valid/ready). Each request yields one result,
//            except a free into a full stack, which yields a spill run of
//            LIST_SIZE+1 words (count, then entries bottom up); last marks
//            the final result of a request.
//   A taken request is captured, then its first result is loaded into the
//   output register; an allocate on a non-empty stack reads the top entry
//   of the store before its result is formed. The sequencer handles one
//   request at a time and walks the entry store for spills.
//   Reset clears the count, the fill state and the entry valid bits, so
//   all entries read as zero; no clearing pass is needed.
//   A stalled receiver holds the output register; the sequencer waits on
//   it, while a new request may be taken as soon as the last result of
//   the previous one sits in the output register.
module chained_free_block_list #(
   parameter int LIST_SIZE = cfbl_pkg::LIST_SIZE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cfbl_pkg::cfbl_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cfbl_pkg::cfbl_rsp_type rsp_data
);
   localparam int AW = $clog2(LIST_SIZE);

   logic                   res_valid;
   logic                   res_ready;
   cfbl_pkg::cfbl_rsp_type res_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [15:0]            wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [15:0]            rd_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   cfbl_pkg::cfbl_rsp_type rsp_data_ff, rsp_data_in;

   cfbl_ctrl #(
      .LIST_SIZE (LIST_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   cfbl_store #(
      .LIST_SIZE (LIST_SIZE)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register: loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/cfbl_list_checker.sv]
// Checker for the chained free-block list: watches the request and result
// channels, predicts results from its own copy of the block stack and compares.
// Depends on cfbl_pkg.
`timescale 1ns / 1ps

module cfbl_list_checker #(
   parameter int LIST_SIZE = cfbl_pkg::LIST_SIZE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  cfbl_pkg::cfbl_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cfbl_pkg::cfbl_rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     outstanding,
   output logic                   fill_waiting,
   output int                     fill_index,
   output int                     request_count,
   output int                     result_count,
   output int                     spill_runs,
   output int                     refills_loaded,
   output int                     no_space_count,
   output int                     busy_count
);
   // predicted block stack and chained-block fill state
   logic [15:0]            stack_words [LIST_SIZE];
   logic [5:0]             stack_depth;
   logic                   refill_open;
   logic [5:0]             refill_pos;
   cfbl_pkg::cfbl_rsp_type expected_results [$];

   function automatic cfbl_pkg::cfbl_rsp_type make_result(cfbl_pkg::cfbl_kind_type kind,
                                                          logic [15:0] blk,
                                                          logic [15:0] word,
                                                          logic refill, logic last);
      cfbl_pkg::cfbl_rsp_type res;
      res.kind          = kind;
      res.block_number  = blk;
      res.spill_word    = word;
      res.refill_needed = refill;
      res.last          = last;
      return res;
   endfunction

   // Apply one accepted request to the predicted stack, queue its results
   task automatic apply_request(input cfbl_pkg::cfbl_req_type r);
      int          top;
      logic [15:0] got;
      if (r.opcode == cfbl_pkg::OP_FILL) begin
         if (!refill_open) begin
            busy_count++;
            expected_results.push_back(make_result(cfbl_pkg::KIND_BUSY, '0, '0,
                                                   1'b0, 1'b1));
         end else begin
            if (refill_pos == 0) begin
               // count word, saturated to capacity
               stack_depth = (r.fill_word > LIST_SIZE) ? 6'(LIST_SIZE) : r.fill_word[5:0];
               refill_pos  = 1;
            end else begin
               stack_words[refill_pos - 1] = r.fill_word;
               if (refill_pos >= LIST_SIZE) begin
                  refill_open = 1'b0;
                  refill_pos  = 0;
                  refills_loaded++;
               end else begin
                  refill_pos = refill_pos + 1;
               end
            end
            expected_results.push_back(make_result(cfbl_pkg::KIND_FILL_ACK, '0, '0,
                                                   1'b0, 1'b1));
         end
      end else if (r.opcode == cfbl_pkg::OP_NONE || refill_open) begin
         busy_count++;
         expected_results.push_back(make_result(cfbl_pkg::KIND_BUSY, '0, '0, 1'b0, 1'b1));
      end else if (r.opcode == cfbl_pkg::OP_FREE) begin
         // full stack: spill count and entries to the freed block, then push
         if (stack_depth >= LIST_SIZE) begin
            spill_runs++;
            expected_results.push_back(make_result(cfbl_pkg::KIND_SPILL, r.freed_block,
                                                   16'(stack_depth), 1'b0, 1'b0));
            for (int i = 0; i < LIST_SIZE; i++) begin
               expected_results.push_back(make_result(cfbl_pkg::KIND_SPILL, r.freed_block,
                                                      stack_words[i], 1'b0,
                                                      i == LIST_SIZE - 1));
            end
            stack_depth = 0;
         end else begin
            expected_results.push_back(make_result(cfbl_pkg::KIND_FREED, r.freed_block,
                                                   '0, 1'b0, 1'b1));
         end
         stack_words[stack_depth] = r.freed_block;
         stack_depth = stack_depth + 1;
      end else begin
         // allocate: empty stack or zero end marker means out of space
         if (stack_depth == 0 || stack_words[stack_depth - 1] == 16'd0) begin
            no_space_count++;
            expected_results.push_back(make_result(cfbl_pkg::KIND_NO_SPACE, '0, '0,
                                                   1'b0, 1'b1));
         end else begin
            top              = stack_depth - 1;
            got              = stack_words[top];
            stack_words[top] = '0;
            stack_depth      = 6'(top);
            if (top == 0) begin
               refill_open = 1'b1;
               refill_pos  = 0;
            end
            expected_results.push_back(make_result(cfbl_pkg::KIND_ALLOCATED, got, '0,
                                                   top == 0, 1'b1));
         end
      end
   endtask

   // Compare results, then predict from requests taken at the same edge
   always @(posedge clock) begin
      cfbl_pkg::cfbl_rsp_type want;
      if (reset) begin
         for (int i = 0; i < LIST_SIZE; i++) stack_words[i] = '0;
         stack_depth    = '0;
         refill_open    = 1'b0;
         refill_pos     = '0;
         expected_results.delete();
         mismatch_count = 0;
         request_count  = 0;
         result_count   = 0;
         spill_runs     = 0;
         refills_loaded = 0;
         no_space_count = 0;
         busy_count     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result kind=%0d blk=%h word=%h refill=%b last=%b",
                           $realtime, rsp_data.kind, rsp_data.block_number,
                           rsp_data.spill_word, rsp_data.refill_needed, rsp_data.last);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.kind !== want.kind ||
                   rsp_data.block_number !== want.block_number ||
                   rsp_data.spill_word !== want.spill_word ||
                   rsp_data.refill_needed !== want.refill_needed ||
                   rsp_data.last !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected kind=%0d blk=%h word=%h refill=%b last=%b",
                              want.kind, want.block_number, want.spill_word,
                              want.refill_needed, want.last);
                     $display("   actual   kind=%0d blk=%h word=%h refill=%b last=%b",
                              rsp_data.kind, rsp_data.block_number, rsp_data.spill_word,
                              rsp_data.refill_needed, rsp_data.last);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            request_count++;
            apply_request(req_data);
         end
      end
      outstanding  = expected_results.size();
      fill_waiting = refill_open;
      fill_index   = refill_pos;
   end

endmodule

[tb/tb_chained_free_block_list.sv]
// Testbench top for the chained free-block list: clock, reset, request and
// result channel drivers, watchdog and verdict. Depends on cfbl_pkg,
// chained_free_block_list and cfbl_list_checker.
`timescale 1ns / 1ps

module tb_chained_free_block_list;

   localparam int LIST_SIZE     = cfbl_pkg::LIST_SIZE_DEF;
   localparam int RANDOM_TARGET = 260;
   localparam int GAP_PERCENT   = 34;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = LIST_SIZE + 8;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cfbl_pkg::cfbl_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cfbl_pkg::cfbl_rsp_type rsp_data;

   bit send_gaps    = 1'b1;
   bit recv_gaps    = 1'b1;
   bit hold_request = 1'b0;
   int idle_cycles  = 0;
   int useful       = 0;

   int   mismatch_count, outstanding, fill_index, request_count, result_count;
   int   spill_runs, refills_loaded, no_space_count, busy_count;
   logic fill_waiting;

   chained_free_block_list #(.LIST_SIZE(LIST_SIZE)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cfbl_list_checker #(.LIST_SIZE(LIST_SIZE)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .fill_waiting   (fill_waiting),
      .fill_index     (fill_index),
      .request_count  (request_count),
      .result_count   (result_count),
      .spill_runs     (spill_runs),
      .refills_loaded (refills_loaded),
      .no_space_count (no_space_count),
      .busy_count     (busy_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result receiver: random stalls, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (recv_gaps && $urandom_range(99) < GAP_PERCENT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long with nothing accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no channel activity for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic cfbl_pkg::cfbl_req_type make_request(logic [1:0] op, logic [15:0] blk,
                                                           logic [15:0] word);
      cfbl_pkg::cfbl_req_type r;
      r.opcode      = op;
      r.freed_block = blk;
      r.fill_word   = word;
      return r;
   endfunction

   // Block numbers for frees, with an occasional zero end marker
   function automatic logic [15:0] rand_block();
      return ($urandom_range(31) == 0) ? 16'd0 : 16'($urandom);
   endfunction

   // Count word first (often above capacity), then entries with some zeros
   function automatic logic [15:0] pick_fill_word(int position);
      int pick;
      if (position == 0) begin
         pick = $urandom_range(99);
         if (pick < 50) return 16'(LIST_SIZE);
         if (pick < 70) return 16'($urandom_range(LIST_SIZE));
         if (pick < 85) return 16'($urandom_range(63, LIST_SIZE + 1));
         return 16'($urandom);
      end
      return ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
   endfunction

   // Present one request from a falling edge; returns at the falling edge after it is taken
   task automatic offer_request(input cfbl_pkg::cfbl_req_type r);
      while (send_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Requests that the block only rejects do not count toward the random target
   task automatic send_counted(input cfbl_pkg::cfbl_req_type r);
      bit rejected;
      rejected = (r.opcode == cfbl_pkg::OP_NONE) ||
                 ((r.opcode == cfbl_pkg::OP_FILL) != fill_waiting);
      offer_request(r);
      if (!rejected) useful++;
   endtask

   // Stimulus
   initial begin
      int         pick;
      int         run;
      bit         hold_done;
      bit         pause_done;
      logic [1:0] op;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty stack, stray fill, unused opcode, refill start, busy rejects
      offer_request(make_request(cfbl_pkg::OP_ALLOC, 16'h0000, 16'h0000));
      offer_request(make_request(cfbl_pkg::OP_FILL,  16'h0000, 16'hFFFF));
      offer_request(make_request(cfbl_pkg::OP_NONE,  16'hFFFF, 16'hFFFF));
      offer_request(make_request(cfbl_pkg::OP_FREE,  16'h8001, 16'h0000));
      offer_request(make_request(cfbl_pkg::OP_ALLOC, 16'hFFFF, 16'h0000));
      offer_request(make_request(cfbl_pkg::OP_FREE,  16'hFFFF, 16'h0000));
      offer_request(make_request(cfbl_pkg::OP_ALLOC, 16'h0000, 16'hFFFF));
      offer_request(make_request(cfbl_pkg::OP_NONE,  16'h0000, 16'h0000));
      offer_request(make_request(cfbl_pkg::OP_FILL,  16'h0000, 16'hFFFF));

      // random: runs of frees and allocates, refills completed word by word
      while (useful < RANDOM_TARGET) begin
         send_gaps = !(useful >= 100 && useful < 140);
         recv_gaps = send_gaps;
         if (!hold_done && useful >= 60) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!pause_done && useful >= 170) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
            pause_done = 1'b1;
         end
         if (fill_waiting) begin
            if ($urandom_range(9) == 0) begin
               pick = $urandom_range(2);
               op   = (pick == 0) ? cfbl_pkg::OP_FREE :
                      (pick == 1) ? cfbl_pkg::OP_ALLOC : cfbl_pkg::OP_NONE;
               send_counted(make_request(op, 16'($urandom), 16'($urandom)));
            end else begin
               send_counted(make_request(cfbl_pkg::OP_FILL, 16'($urandom),
                                         pick_fill_word(fill_index)));
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               run = $urandom_range(40, 1);
               for (int k = 0; k < run; k++) begin
                  if (fill_waiting) break;
                  send_counted(make_request(cfbl_pkg::OP_FREE, rand_block(), 16'($urandom)));
               end
            end else if (pick < 85) begin
               run = $urandom_range(36, 1);
               for (int k = 0; k < run; k++) begin
                  if (fill_waiting) break;
                  send_counted(make_request(cfbl_pkg::OP_ALLOC, 16'($urandom),
                                            16'($urandom)));
               end
            end else if (pick < 93) begin
               send_counted(make_request(cfbl_pkg::OP_FILL, 16'($urandom), 16'($urandom)));
            end else begin
               send_counted(make_request(cfbl_pkg::OP_NONE, 16'($urandom), 16'($urandom)));
            end
         end
      end

      // drain
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d requests and %0d results: %0d spill runs, %0d refills loaded,",
               request_count, result_count, spill_runs, refills_loaded);
      $display("%0d out-of-space allocations, %0d rejected requests, hold-off and drain pause.",
               no_space_count, busy_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
